// ----- design/bfg_pkg.sv -----
`default_nettype none

package bfg_pkg;

    // Field widths.
    localparam int UV_W    = 23;
    localparam int PIN_W   = 17;
    localparam int TIME_W  = 32;
    localparam int PCT_W   = 7;
    localparam int GAIN_W  = 16;
    localparam int OFS_W   = 20;
    localparam int RINT_W  = 16;
    localparam int HINT_W  = 20;
    localparam int CFG_W   = 20;
    localparam int CFGI_W  = 3;

    // History ring.
    localparam int HIST_DEPTH = 10;
    localparam int SLOT_W     = $clog2(HIST_DEPTH);
    localparam int RECENT_SLOTS = 3;

    // Scaling: reading = sum * 1000 * gain / (24 * 4096), rounded.
    // 24 * 4096 = 3 * 2^15, so the division is a shift and a divide by three.
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam logic [MUL_W-1:0] MV_TO_UV   = 32'd1000;
    localparam logic [MUL_W-1:0] RECIP3     = 32'hAAAA_AAAB;
    localparam int   RECIP3_SHIFT = 33;
    localparam int   DEN_SHIFT    = 15;
    localparam int   UVSUM_W      = 27;
    localparam int   SCALED_W     = 43;
    localparam int   ROUND_W      = SCALED_W + 1;
    localparam logic [ROUND_W-1:0] ROUND_HALF = 44'd49152;
    localparam int   QUO_W        = 27;
    localparam int   SUM_W        = 29;

    localparam logic [UV_W-1:0] UV_MAX    = 23'd8388607;
    localparam logic [UV_W-1:0] WIN_LO_UV = 23'd2000000;
    localparam logic [UV_W-1:0] WIN_HI_UV = 23'd5000000;
    localparam logic [UV_W-1:0] FULL_UV   = 23'd4170000;
    localparam logic [UV_W-1:0] ONCHG_UV  = 23'd4050000;
    localparam logic [UV_W-1:0] CLIMB_UV  = 23'd12000;
    localparam logic [UV_W-1:0] INIT_UV   = 23'd3900000;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd8192;
    localparam logic [RINT_W-1:0] RINT_RST = 16'd2000;
    localparam logic [HINT_W-1:0] HINT_RST = 20'd60000;

    // Charge table.
    localparam int LUT_N   = 12;
    localparam int SEG_W   = $clog2(LUT_N);
    localparam int DV_W    = 18;
    localparam int DP_W    = 4;
    localparam int REM_W   = 22;
    localparam int DIV_STEPS = 4;
    localparam int CNT_W   = $clog2(DIV_STEPS);
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    localparam logic [UV_W-1:0] LUT_UV [0:LUT_N-1] = '{
        23'd4200000, 23'd4100000, 23'd4000000, 23'd3900000, 23'd3830000, 23'd3780000,
        23'd3730000, 23'd3680000, 23'd3620000, 23'd3520000, 23'd3400000, 23'd3200000};
    localparam logic [PCT_W-1:0] LUT_PCT [0:LUT_N-1] = '{
        7'd100, 7'd92, 7'd82, 7'd68, 7'd55, 7'd45,
        7'd35, 7'd24, 7'd15, 7'd7, 7'd2, 7'd0};

    typedef enum logic [CFGI_W-1:0] {
        CFG_GAIN   = 3'd0,
        CFG_OFFSET = 3'd1,
        CFG_RINT   = 3'd2,
        CFG_HINT   = 3'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CHG_FULL     = 2'd0,
        CHG_CHARGING = 2'd1,
        CHG_IDLE     = 2'd2
    } chg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MULK, S_MULG, S_MULR, S_SAT, S_UPD, S_SEG, S_DIV, S_FIN
    } state_t;

    typedef struct packed {
        logic             load;
        logic             mul_k;
        logic             mul_g;
        logic             mul_r;
        logic             sat;
        logic             upd;
        logic             seg;
        logic             div;
        logic             div_first;
        logic [CNT_W-1:0] div_bit;
        logic             write_out;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // Segment of the table holding v: the smallest index i >= 1 with v >= LUT_UV[i].
    function automatic logic [SEG_W-1:0] seg_index(input logic [UV_W-1:0] v);
        logic [SEG_W-1:0] idx;
        idx = SEG_W'(LUT_N - 1);
        for (int i = LUT_N - 1; i >= 1; i--) begin
            if (v >= LUT_UV[i]) begin
                idx = SEG_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- design/bfg_ctrl.sv -----
`default_nettype none

module bfg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bfg_pkg::status_t status,
    output bfg_pkg::cmd_t         cmd
);

    bfg_pkg::state_t              state_reg, state_next;
    logic [bfg_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfg_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            bfg_pkg::S_IDLE: if (in_valid) state_next = bfg_pkg::S_MULK;
            bfg_pkg::S_MULK: state_next = bfg_pkg::S_MULG;
            bfg_pkg::S_MULG: state_next = bfg_pkg::S_MULR;
            bfg_pkg::S_MULR: state_next = bfg_pkg::S_SAT;
            bfg_pkg::S_SAT:  state_next = bfg_pkg::S_UPD;
            bfg_pkg::S_UPD:  state_next = bfg_pkg::S_SEG;
            bfg_pkg::S_SEG:
            begin
                state_next = bfg_pkg::S_DIV;
                cnt_next   = bfg_pkg::CNT_W'(bfg_pkg::DIV_STEPS - 1);
            end
            bfg_pkg::S_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) state_next = bfg_pkg::S_FIN;
            end
            bfg_pkg::S_FIN: if (!status.out_busy) state_next = bfg_pkg::S_IDLE;
            default: state_next = bfg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready          = (state_reg == bfg_pkg::S_IDLE);
        cmd               = '0;
        cmd.load          = (state_reg == bfg_pkg::S_IDLE) && in_valid;
        cmd.mul_k         = (state_reg == bfg_pkg::S_MULK);
        cmd.mul_g         = (state_reg == bfg_pkg::S_MULG);
        cmd.mul_r         = (state_reg == bfg_pkg::S_MULR);
        cmd.sat           = (state_reg == bfg_pkg::S_SAT);
        cmd.upd           = (state_reg == bfg_pkg::S_UPD);
        cmd.seg           = (state_reg == bfg_pkg::S_SEG);
        cmd.div           = (state_reg == bfg_pkg::S_DIV);
        cmd.div_first     = (cnt_reg == bfg_pkg::CNT_W'(bfg_pkg::DIV_STEPS - 1));
        cmd.div_bit       = cnt_reg;
        cmd.write_out     = (state_reg == bfg_pkg::S_FIN) && !status.out_busy;
    end

endmodule

`default_nettype wire

// ----- design/bfg_dpath.sv -----
`default_nettype none

module bfg_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bfg_pkg::cmd_t                 cmd,
    output bfg_pkg::status_t                   status,
    input  wire logic                          cfg_we,
    input  wire logic [bfg_pkg::CFGI_W-1:0]    cfg_idx,
    input  wire logic [bfg_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          mode,
    input  wire logic [bfg_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [bfg_pkg::PIN_W-1:0]     pin_mv_sum,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [bfg_pkg::UV_W-1:0]           volts_uv,
    output logic [1:0]                         charge_state,
    output logic [bfg_pkg::PCT_W-1:0]          percent,
    output logic                               reading_taken
);

    localparam int UV_W   = bfg_pkg::UV_W;
    localparam int SLOT_W = bfg_pkg::SLOT_W;

    // Configuration.
    logic [bfg_pkg::GAIN_W-1:0] gain_reg;
    logic signed [bfg_pkg::OFS_W-1:0] ofs_reg;
    logic [bfg_pkg::RINT_W-1:0] rint_reg;
    logic [bfg_pkg::HINT_W-1:0] hint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= bfg_pkg::GAIN_RST;
            ofs_reg  <= '0;
            rint_reg <= bfg_pkg::RINT_RST;
            hint_reg <= bfg_pkg::HINT_RST;
        end
        else if (cfg_we)
        begin
            unique case (bfg_pkg::cfg_idx_t'(cfg_idx))
                bfg_pkg::CFG_GAIN:   gain_reg <= cfg_wdata[bfg_pkg::GAIN_W-1:0];
                bfg_pkg::CFG_OFFSET: ofs_reg  <= $signed(cfg_wdata[bfg_pkg::OFS_W-1:0]);
                bfg_pkg::CFG_RINT:   rint_reg <= cfg_wdata[bfg_pkg::RINT_W-1:0];
                bfg_pkg::CFG_HINT:   hint_reg <= cfg_wdata[bfg_pkg::HINT_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured item.
    logic                            mode_reg;
    logic [bfg_pkg::TIME_W-1:0]      now_reg;
    logic [bfg_pkg::PIN_W-1:0]       pin_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            now_reg  <= now_ms;
            pin_reg  <= pin_mv_sum;
        end
    end

    // Shared multiplier.
    logic [bfg_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [bfg_pkg::PROD_W-1:0]  prod_reg, mul_p;
    logic [bfg_pkg::ROUND_W-1:0] rounded;
    logic [UV_W-1:0]             seg_x;
    logic [bfg_pkg::DP_W-1:0]    seg_dp;

    assign rounded = {1'b0, prod_reg[bfg_pkg::SCALED_W-1:0]} + bfg_pkg::ROUND_HALF;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority if (cmd.mul_k)
        begin
            mul_a = bfg_pkg::MUL_W'(pin_reg);
            mul_b = bfg_pkg::MV_TO_UV;
        end
        else if (cmd.mul_g)
        begin
            mul_a = bfg_pkg::MUL_W'(prod_reg[bfg_pkg::UVSUM_W-1:0]);
            mul_b = bfg_pkg::MUL_W'(gain_reg);
        end
        else if (cmd.mul_r)
        begin
            mul_a = bfg_pkg::MUL_W'(rounded[bfg_pkg::ROUND_W-1:bfg_pkg::DEN_SHIFT]);
            mul_b = bfg_pkg::RECIP3;
        end
        else if (cmd.seg)
        begin
            mul_a = bfg_pkg::MUL_W'(seg_x);
            mul_b = bfg_pkg::MUL_W'(seg_dp);
        end
        else
        begin
            mul_a = '0;
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_k || cmd.mul_g || cmd.mul_r || cmd.seg)
            prod_reg <= mul_p;
    end

    // Offset and saturation.
    logic [bfg_pkg::QUO_W-1:0]        quo;
    logic signed [bfg_pkg::SUM_W-1:0] ofs_sum;
    logic [UV_W-1:0]                  sat_uv, rd_reg;

    assign quo     = prod_reg[bfg_pkg::RECIP3_SHIFT+bfg_pkg::QUO_W-1:bfg_pkg::RECIP3_SHIFT];
    assign ofs_sum = $signed({2'b00, quo}) + bfg_pkg::SUM_W'(ofs_reg);

    always_comb
    begin
        priority if (ofs_sum < 0)
            sat_uv = '0;
        else if (ofs_sum > $signed(bfg_pkg::SUM_W'(bfg_pkg::UV_MAX)))
            sat_uv = bfg_pkg::UV_MAX;
        else
            sat_uv = ofs_sum[UV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sat) rd_reg <= sat_uv;
    end

    // Gauge state.
    logic [UV_W-1:0]            smooth_reg, smooth_next;
    logic [UV_W-1:0]            ring_reg [bfg_pkg::HIST_DEPTH];
    logic [UV_W-1:0]            ring_next [bfg_pkg::HIST_DEPTH];
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic                       filled_reg, filled_next;
    logic [bfg_pkg::TIME_W-1:0] lread_reg, lread_next, lstore_reg, lstore_next;
    logic                       taken_reg, taken_next;
    logic [bfg_pkg::TIME_W-1:0] since_read, since_store;
    logic [UV_W+1:0]            avg_sum;
    logic [UV_W-1:0]            avg_uv;
    logic                       gate_open, in_window, hist_due;

    assign since_read  = now_reg - lread_reg;
    assign since_store = now_reg - lstore_reg;
    assign gate_open   = since_read >= bfg_pkg::TIME_W'(rint_reg);
    assign hist_due    = since_store > bfg_pkg::TIME_W'(hint_reg);
    assign in_window   = (rd_reg > bfg_pkg::WIN_LO_UV) && (rd_reg < bfg_pkg::WIN_HI_UV);
    assign avg_sum     = {2'b00, smooth_reg} + {1'b0, smooth_reg, 1'b0}
                       + {2'b00, rd_reg} + (UV_W+2)'(2);
    assign avg_uv      = avg_sum[UV_W+1:2];

    always_comb
    begin
        smooth_next = smooth_reg;
        ring_next   = ring_reg;
        slot_next   = slot_reg;
        filled_next = filled_reg;
        lread_next  = lread_reg;
        lstore_next = lstore_reg;
        taken_next  = taken_reg;
        if (cmd.upd)
        begin
            priority if (mode_reg)
            begin
                smooth_next = rd_reg;
                for (int i = 0; i < bfg_pkg::HIST_DEPTH; i++) ring_next[i] = rd_reg;
                taken_next  = 1'b1;
            end
            else if (gate_open)
            begin
                lread_next = now_reg;
                taken_next = 1'b1;
                if (in_window) smooth_next = avg_uv;
                if (hist_due)
                begin
                    lstore_next         = now_reg;
                    ring_next[slot_reg] = smooth_next;
                    if (slot_reg == SLOT_W'(bfg_pkg::HIST_DEPTH - 1))
                    begin
                        slot_next   = '0;
                        filled_next = 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            else
            begin
                taken_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= bfg_pkg::INIT_UV;
            for (int i = 0; i < bfg_pkg::HIST_DEPTH; i++) ring_reg[i] <= '0;
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            lread_reg  <= '0;
            lstore_reg <= '0;
            taken_reg  <= 1'b0;
        end
        else
        begin
            smooth_reg <= smooth_next;
            ring_reg   <= ring_next;
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            lread_reg  <= lread_next;
            lstore_reg <= lstore_next;
            taken_reg  <= taken_next;
        end
    end

    // Table segment and charge class.
    logic [bfg_pkg::SEG_W-1:0]  seg_idx;
    logic [bfg_pkg::DV_W-1:0]   dv_reg;
    logic [bfg_pkg::PCT_W-1:0]  base_reg;
    logic                       hi_reg, lo_reg;
    logic [1:0]                 cls, cls_reg;
    logic [UV_W-1:0]            oldest;
    logic [UV_W-1:0]            dv_full;
    logic [bfg_pkg::PCT_W-1:0]  dp_full;

    assign seg_idx = bfg_pkg::seg_index(smooth_reg);
    assign seg_x   = smooth_reg - bfg_pkg::LUT_UV[seg_idx];
    assign dv_full = bfg_pkg::LUT_UV[seg_idx - 1'b1] - bfg_pkg::LUT_UV[seg_idx];
    assign dp_full = bfg_pkg::LUT_PCT[seg_idx - 1'b1] - bfg_pkg::LUT_PCT[seg_idx];
    assign seg_dp  = dp_full[bfg_pkg::DP_W-1:0];
    assign oldest  = ring_reg[slot_reg];

    always_comb
    begin
        priority if (smooth_reg >= bfg_pkg::FULL_UV)
            cls = bfg_pkg::CHG_FULL;
        else if (smooth_reg >= bfg_pkg::ONCHG_UV)
            cls = bfg_pkg::CHG_CHARGING;
        else if ((filled_reg || slot_reg > SLOT_W'(bfg_pkg::RECENT_SLOTS))
                 && smooth_reg > oldest && (smooth_reg - oldest) > bfg_pkg::CLIMB_UV)
            cls = bfg_pkg::CHG_CHARGING;
        else
            cls = bfg_pkg::CHG_IDLE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seg)
        begin
            dv_reg   <= dv_full[bfg_pkg::DV_W-1:0];
            base_reg <= bfg_pkg::LUT_PCT[seg_idx];
            hi_reg   <= smooth_reg >= bfg_pkg::LUT_UV[0];
            lo_reg   <= smooth_reg < bfg_pkg::LUT_UV[bfg_pkg::LUT_N-1];
            cls_reg  <= cls;
        end
    end

    // Restoring division of the interpolation term, one quotient bit a cycle.
    logic [bfg_pkg::REM_W-1:0]     rem_reg, rem_in, trial;
    logic [bfg_pkg::DIV_STEPS-1:0] q_reg;

    assign rem_in = cmd.div_first
                  ? prod_reg[bfg_pkg::REM_W-1:0] + bfg_pkg::REM_W'(dv_reg[bfg_pkg::DV_W-1:1])
                  : rem_reg;
    assign trial  = bfg_pkg::REM_W'(dv_reg) << cmd.div_bit;

    always_ff @(posedge clk)
    begin
        if (cmd.seg)
        begin
            q_reg <= '0;
        end
        else if (cmd.div)
        begin
            if (rem_in >= trial)
            begin
                rem_reg              <= rem_in - trial;
                q_reg[cmd.div_bit]   <= 1'b1;
            end
            else
            begin
                rem_reg <= rem_in;
            end
        end
    end

    // Output register.
    logic [bfg_pkg::PCT_W-1:0] pct;
    logic                      ovalid_reg;

    always_comb
    begin
        priority if (hi_reg)
            pct = bfg_pkg::PCT_FULL;
        else if (lo_reg)
            pct = bfg_pkg::PCT_EMPTY;
        else
            pct = base_reg + bfg_pkg::PCT_W'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.write_out)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_out)
        begin
            volts_uv      <= smooth_reg;
            charge_state  <= cls_reg;
            percent       <= pct;
            reading_taken <= taken_reg;
        end
    end

    assign out_valid       = ovalid_reg;
    assign status.out_busy = ovalid_reg && !out_ready;

endmodule

`default_nettype wire

// ----- design/battery_fuel_gauge_unit.sv -----
`default_nettype none

// Battery fuel gauge. Each input item carries the sum of 24 pin readings in
// millivolts, the current millisecond time and a mode bit; each item yields
// exactly one result item with the smoothed voltage in microvolts, a charge
// class, a state-of-charge percentage and a flag saying whether a reading was
// taken. The reading is scaled by the divider gain (Q4.12), rounded, shifted by
// the signed offset and clamped to 0..8388607 uV. In update mode the reading is
// taken only once the read interval has elapsed; a taken reading strictly
// between 2 V and 5 V moves a quarter-weight average, and once the history
// interval has been exceeded the average is stored in a ten-slot ring.
// Initialize mode loads the average and the whole ring with the reading.
// An item goes from acceptance to its presented result by three passes through
// one shared 32 x 32 multiplier for the scaling, then clamping, state update,
// table lookup, a bit-serial divider for the interpolation and the load of the
// output register. The gauge works on one item at a time; it returns to idle
// and accepts a new item once the previous result has been loaded into the
// output register, even while that result still waits for out_ready.
// Configuration registers are written through cfg_we, cfg_idx and cfg_wdata;
// the user must write them only while the gauge is idle, which the block itself
// does not enforce. Indexes above three are ignored.

module battery_fuel_gauge_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bfg_pkg::CFGI_W-1:0]    cfg_idx,
    input  wire logic [bfg_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [bfg_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [bfg_pkg::PIN_W-1:0]     pin_mv_sum,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bfg_pkg::UV_W-1:0]           volts_uv,
    output logic [1:0]                         charge_state,
    output logic [bfg_pkg::PCT_W-1:0]          percent,
    output logic                               reading_taken
);

    bfg_pkg::cmd_t    cmd;
    bfg_pkg::status_t status;

    // The controller sequences one item at a time through the datapath.
    bfg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the gauge state and the result.
    bfg_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .now_ms        (now_ms),
        .pin_mv_sum    (pin_mv_sum),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .volts_uv      (volts_uv),
        .charge_state  (charge_state),
        .percent       (percent),
        .reading_taken (reading_taken)
    );

`ifndef SYNTH
    // Once an item is taken the gauge is busy until it has worked it through.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("gauge accepted a second item back to back");

    // The percentage stays on the table's range.
    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> percent <= bfg_pkg::PCT_FULL)
        else $error("percent above full scale");

    // A full charge class only comes with a high voltage.
    a_full_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && charge_state == bfg_pkg::CHG_FULL |-> volts_uv >= bfg_pkg::FULL_UV)
        else $error("full class below the full threshold");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // Expected output of one item.
    typedef struct {
        logic [bfg_pkg::UV_W-1:0]  volts;
        logic [1:0]                chg;
        logic [bfg_pkg::PCT_W-1:0] pct;
        logic                      taken;
    } gauge_result_t;

    // Scoreboard: keeps its own copy of the gauge state and registers, works out
    // the result of every accepted item and checks the results in order.
    class scoreboard_t;
        logic [bfg_pkg::GAIN_W-1:0] gain;
        int                         offset;
        logic [bfg_pkg::RINT_W-1:0] read_int;
        logic [bfg_pkg::HINT_W-1:0] hist_int;
        logic [bfg_pkg::UV_W-1:0]   avg_uv;
        logic [bfg_pkg::UV_W-1:0]   ring [bfg_pkg::HIST_DEPTH];
        int                         slot;
        bit                         filled;
        logic [31:0]                last_read;
        logic [31:0]                last_store;
        gauge_result_t              pending[$];
        int                         errors;

        function void clear();
            gain = bfg_pkg::GAIN_RST;
            offset = 0;
            read_int = bfg_pkg::RINT_RST;
            hist_int = bfg_pkg::HINT_RST;
            avg_uv = bfg_pkg::INIT_UV;
            foreach (ring[i]) ring[i] = '0;
            slot = 0;
            filled = 0;
            last_read = '0;
            last_store = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(bfg_pkg::cfg_idx_t idx, logic [bfg_pkg::CFG_W-1:0] val);
            case (idx)
                bfg_pkg::CFG_GAIN:   gain = val[bfg_pkg::GAIN_W-1:0];
                bfg_pkg::CFG_OFFSET: offset = $signed(val[bfg_pkg::OFS_W-1:0]);
                bfg_pkg::CFG_RINT:   read_int = val[bfg_pkg::RINT_W-1:0];
                bfg_pkg::CFG_HINT:   hist_int = val[bfg_pkg::HINT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [bfg_pkg::UV_W-1:0] scaled_uv(logic [bfg_pkg::PIN_W-1:0] pin);
            longint num;
            longint v;
            num = longint'(pin) * 1000 * longint'(gain);
            v = (num + 49152) / 98304 + offset;
            if (v < 0) return '0;
            if (v > 8388607) return bfg_pkg::UV_MAX;
            return v[bfg_pkg::UV_W-1:0];
        endfunction

        function logic [1:0] charge_of();
            logic [bfg_pkg::UV_W-1:0] oldest;
            oldest = ring[slot];
            if (avg_uv >= bfg_pkg::FULL_UV) return bfg_pkg::CHG_FULL;
            if (avg_uv >= bfg_pkg::ONCHG_UV) return bfg_pkg::CHG_CHARGING;
            if ((filled || slot > 3) && avg_uv > oldest
                && avg_uv - oldest > bfg_pkg::CLIMB_UV)
                return bfg_pkg::CHG_CHARGING;
            return bfg_pkg::CHG_IDLE;
        endfunction

        function logic [bfg_pkg::PCT_W-1:0] percent_of();
            longint dv;
            longint dp;
            if (avg_uv >= bfg_pkg::LUT_UV[0]) return bfg_pkg::PCT_FULL;
            for (int i = 1; i < bfg_pkg::LUT_N; i++)
            begin
                if (avg_uv >= bfg_pkg::LUT_UV[i])
                begin
                    dv = bfg_pkg::LUT_UV[i-1] - bfg_pkg::LUT_UV[i];
                    dp = bfg_pkg::LUT_PCT[i-1] - bfg_pkg::LUT_PCT[i];
                    return bfg_pkg::PCT_W'((longint'(bfg_pkg::LUT_PCT[i]) * dv
                        + longint'(avg_uv - bfg_pkg::LUT_UV[i]) * dp + dv / 2) / dv);
                end
            end
            return bfg_pkg::PCT_EMPTY;
        endfunction

        // Notes an accepted input item and queues its result.
        function void note_item(logic md, logic [31:0] now, logic [bfg_pkg::PIN_W-1:0] pin);
            gauge_result_t r;
            logic [bfg_pkg::UV_W-1:0] rd;
            r.taken = 0;
            if (md)
            begin
                avg_uv = scaled_uv(pin);
                foreach (ring[i]) ring[i] = avg_uv;
                r.taken = 1;
            end
            else if (32'(now - last_read) >= read_int)
            begin
                last_read = now;
                r.taken = 1;
                rd = scaled_uv(pin);
                if (rd > bfg_pkg::WIN_LO_UV && rd < bfg_pkg::WIN_HI_UV)
                    avg_uv = bfg_pkg::UV_W'((3 * longint'(avg_uv) + rd + 2) / 4);
                if (32'(now - last_store) > hist_int)
                begin
                    last_store = now;
                    ring[slot] = avg_uv;
                    slot = (slot + 1) % bfg_pkg::HIST_DEPTH;
                    if (slot == 0) filled = 1;
                end
            end
            r.volts = avg_uv;
            r.chg = charge_of();
            r.pct = percent_of();
            pending.push_back(r);
        endfunction

        // Checks one result against the oldest expectation.
        function void check_result(logic [bfg_pkg::UV_W-1:0] v, logic [1:0] c,
                                   logic [bfg_pkg::PCT_W-1:0] p, logic t);
            gauge_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result volts %0d", $time, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.volts)
            begin
                $display("%0t: volts_uv expected %0d got %0d", $time, e.volts, v);
                errors++;
            end
            if (c !== e.chg)
            begin
                $display("%0t: charge_state expected %0d got %0d", $time, e.chg, c);
                errors++;
            end
            if (p !== e.pct)
            begin
                $display("%0t: percent expected %0d got %0d", $time, e.pct, p);
                errors++;
            end
            if (t !== e.taken)
            begin
                $display("%0t: reading_taken expected %0d got %0d", $time, e.taken, t);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [bfg_pkg::CFGI_W-1:0] cfg_idx;
    logic [bfg_pkg::CFG_W-1:0]  cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic                       mode;
    logic [31:0]                now_ms;
    logic [bfg_pkg::PIN_W-1:0]  pin_mv_sum;
    logic                       out_valid;
    logic                       out_ready;
    logic [bfg_pkg::UV_W-1:0]   volts_uv;
    logic [1:0]                 charge_state;
    logic [bfg_pkg::PCT_W-1:0]  percent;
    logic                       reading_taken;

    scoreboard_t sb;
    int  send_idle_pct;
    int  stall_pct;
    int  cycles;
    logic [31:0] clock_ms;

    battery_fuel_gauge_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .now_ms(now_ms), .pin_mv_sum(pin_mv_sum),
        .out_valid(out_valid), .out_ready(out_ready),
        .volts_uv(volts_uv), .charge_state(charge_state),
        .percent(percent), .reading_taken(reading_taken)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Cycle limit: room for every item plus long stalls, many times over.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // The receiver stalls at random and checks every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(volts_uv, charge_state, percent, reading_taken);
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Writes one register while the gauge is idle.
    task automatic write_reg(bfg_pkg::cfg_idx_t idx, logic [bfg_pkg::CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // Presents one item, holding it until accepted; idle gaps go before it.
    // Valid stays high after acceptance until the next item or an idle cycle.
    task automatic send_item(logic md, logic [31:0] now, logic [bfg_pkg::PIN_W-1:0] pin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        mode <= md;
        now_ms <= now;
        pin_mv_sum <= pin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(md, now, pin);
    endtask

    // Waits until every result is in, then lets the pipeline drain.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly well-paced update readings in the useful voltage range, with
    // occasional initialise items, full-range pins and irregular time steps.
    task automatic random_items(int n);
        logic [bfg_pkg::PIN_W-1:0] pin;
        logic [31:0] step;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: pin = bfg_pkg::PIN_W'($urandom_range(79200));
                1: pin = bfg_pkg::PIN_W'($urandom);
                default: pin = bfg_pkg::PIN_W'($urandom_range(48000, 62000));
            endcase
            case ($urandom_range(7))
                0: step = $urandom;
                1: step = $urandom_range(1999);
                2: step = $urandom_range(70000);
                default: step = $urandom_range(2000, 20000);
            endcase
            clock_ms += step;
            send_item($urandom_range(29) == 0, clock_ms, pin);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_wdata = '0;
        in_valid = 0;
        mode = 0;
        now_ms = '0;
        pin_mv_sum = '0;
        out_ready = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        clock_ms = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset settings, gate closed and open, window edges,
        // initialise, table ends and a bogus register index.
        send_item(0, 32'd100, 17'd50000);
        send_item(0, 32'd2000, 17'd56000);
        send_item(0, 32'd3999, 17'd56000);
        send_item(1, 32'd4000, 17'd0);
        send_item(0, 32'd4000, 17'd24576);
        send_item(0, 32'd70000, 17'd61440);
        send_item(0, 32'd72000, 17'd73728);
        send_item(1, 32'd72001, 17'd79200);
        send_item(1, 32'd72002, 17'h1FFFF);
        send_item(1, 32'd72003, 17'd50400);
        send_item(1, 32'd72004, 17'd38400);
        send_item(0, 32'hFFFF_FFFF, 17'd60000);
        send_item(0, 32'd5000, 17'd60000);
        drain();
        write_reg(bfg_pkg::CFG_GAIN, 20'hFFFF);
        write_reg(bfg_pkg::CFG_OFFSET, 20'h80000);
        write_reg(bfg_pkg::CFG_RINT, 20'd0);
        write_reg(bfg_pkg::CFG_HINT, 20'd0);
        write_reg(bfg_pkg::cfg_idx_t'(3'd5), 20'hFFFFF);
        for (int k = 0; k < 12; k++) send_item(k == 0, 32'(k), 17'(k * 6600));
        drain();

        // Random phases with different registers and idling.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(bfg_pkg::CFG_GAIN, bfg_pkg::GAIN_RST);
                    write_reg(bfg_pkg::CFG_OFFSET, 20'd0);
                    write_reg(bfg_pkg::CFG_RINT, bfg_pkg::RINT_RST);
                    write_reg(bfg_pkg::CFG_HINT, 20'd20000);
                    send_idle_pct = 0; stall_pct = 0;
                end
                1:
                begin
                    write_reg(bfg_pkg::CFG_OFFSET, 20'h7FFFF);
                    write_reg(bfg_pkg::CFG_HINT, 20'hFFFFF);
                    send_idle_pct = 61; stall_pct = 0;
                end
                2:
                begin
                    write_reg(bfg_pkg::CFG_OFFSET, bfg_pkg::CFG_W'(-300000));
                    write_reg(bfg_pkg::CFG_GAIN, 16'd9000);
                    write_reg(bfg_pkg::CFG_RINT, 20'hFFFF);
                    write_reg(bfg_pkg::CFG_HINT, bfg_pkg::HINT_RST);
                    send_idle_pct = 0; stall_pct = 61;
                end
                3:
                begin
                    write_reg(bfg_pkg::CFG_GAIN, 16'd0);
                    write_reg(bfg_pkg::CFG_OFFSET, 20'd500000);
                    write_reg(bfg_pkg::CFG_RINT, 20'd1000);
                    send_idle_pct = 19; stall_pct = 19;
                end
                default:
                begin
                    write_reg(bfg_pkg::CFG_GAIN, 16'(8192 + $urandom_range(400)));
                    write_reg(bfg_pkg::CFG_OFFSET,
                              bfg_pkg::CFG_W'(int'($urandom_range(100000)) - 50000));
                    write_reg(bfg_pkg::CFG_RINT, 20'd2000);
                    write_reg(bfg_pkg::CFG_HINT, 20'd10000);
                    send_idle_pct = 0; stall_pct = 0;
                end
            endcase
            random_items(ph == 3 ? 30 : 90);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/bfg_pkg.sv
design/bfg_ctrl.sv
design/bfg_dpath.sv
design/battery_fuel_gauge_unit.sv
verif/testbench.sv
